/* sv/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the soft timer bank
// Holds the timer count, field widths, item kinds and the countdown unit
// result type.
// ----------------------------------------------------------------------------
package stb_pkg;

    // bank size and derived index width
    localparam int TIMER_COUNT = 4;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    // field widths
    localparam int CNT_W  = 32;
    localparam int ID_W   = 8;
    localparam int KIND_W = 2;

    // run-time counter returns to zero instead of showing this value
    localparam logic [CNT_W-1:0] RUN_LIMIT = '1;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_CHECK = 2'd3
    } kind_t;

    // result of one pass through the shared countdown unit
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             expire;
    } cd_res_t;

endpackage

/* sv/soft_timer_bank.sv */
// ----------------------------------------------------------------------------
// soft_timer_bank: bank of countdown timers with a running tick counter
// Tick walks every timer through one shared countdown unit; start, stop
// and check touch one timer. Every transaction returns one result.
//
//   channel | dir | tdata fields (low bit up)                | tuser
//   s_*     | in  | timer_id[7:0] period[31:0] auto_reload    | kind[1:0]
//   m_*     | out | timed_out run_time[31:0]                  | -
//
// A tick holds the block from accept to the next accept while it reads and
// then writes each timer in turn on the single RAM port and countdown unit;
// start, stop and check visit only their own timer.
// Reset clears all timers through per-entry valid bits, no clearing pass.
// A result waits in the output register; a held result stalls only the
// final step of the following transaction.
// ----------------------------------------------------------------------------
module soft_timer_bank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_id[7:0], period[39:8], auto_reload[40]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // timed_out[0], run_time[32:1]
);
    import stb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_WR   = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    kind_t                kind_reg;
    logic                 id_ok_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     period_reg;
    logic                 auto_reg;
    logic                 hit_reg;
    logic [CNT_W-1:0]     tick_total_reg, tick_total_next;
    logic [TIMER_COUNT-1:0] valid_reg, flag_reg, mode_reg;
    logic                 m_tvalid_reg;
    logic                 out_hit_reg;
    logic [CNT_W-1:0]     out_run_reg;

    logic                 s_fire, out_free;
    logic                 ram_we;
    logic [2*CNT_W-1:0]   ram_wdata, ram_rdata;
    logic [CNT_W-1:0]     cur_count, cur_reload;
    cd_res_t              cd_res;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // counts and preloads, {reload, count} per entry
    stb_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (TIMER_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (idx_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign cur_count  = valid_reg[idx_reg] ? ram_rdata[CNT_W-1:0] : '0;
    assign cur_reload = valid_reg[idx_reg] ? ram_rdata[2*CNT_W-1:CNT_W] : '0;

    stb_cd_unit u_cd (
        .count_in  (cur_count),
        .reload_in (cur_reload),
        .auto_in   (mode_reg[idx_reg]),
        .res       (cd_res)
    );

    // write-back data for the current step
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = {cur_reload, cd_res.count};
        if (state_reg == ST_WR && id_ok_reg)
        begin
            case (kind_reg)
                KIND_TICK:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cur_reload, cd_res.count};
                end
                KIND_START:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {period_reg, period_reg};
                end
                KIND_STOP:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cur_reload, {CNT_W{1'b0}}};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // run-time counter step
    always_comb
    begin
        tick_total_next = tick_total_reg + CNT_W'(1);
        if (tick_total_next == RUN_LIMIT)
        begin
            tick_total_next = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_RD;
                    if (kind_t'(s_tuser) == KIND_TICK)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = s_tdata[IDX_W-1:0];
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (kind_reg == KIND_TICK && idx_reg != IDX_W'(TIMER_COUNT - 1))
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and timer status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            flag_reg       <= '0;
            mode_reg       <= '0;
            tick_total_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (s_fire)
            begin
                hit_reg <= 1'b0;
            end
            // per-timer status update
            if (state_reg == ST_WR && id_ok_reg)
            begin
                case (kind_reg)
                    KIND_TICK:
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        if (cd_res.expire)
                        begin
                            flag_reg[idx_reg] <= 1'b1;
                        end
                    end
                    KIND_START:
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        flag_reg[idx_reg]  <= 1'b0;
                        mode_reg[idx_reg]  <= auto_reg;
                    end
                    KIND_STOP:
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        flag_reg[idx_reg]  <= 1'b0;
                        mode_reg[idx_reg]  <= 1'b0;
                    end
                    default:
                    begin
                        hit_reg           <= flag_reg[idx_reg];
                        flag_reg[idx_reg] <= 1'b0;
                    end
                endcase
            end
            // result hand-off and run-time update
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                if (kind_reg == KIND_TICK)
                begin
                    tick_total_reg <= tick_total_next;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // captured transaction fields and output payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            kind_reg   <= kind_t'(s_tuser);
            id_ok_reg  <= (kind_t'(s_tuser) == KIND_TICK) ||
                          (s_tdata[ID_W-1:0] < ID_W'(TIMER_COUNT));
            period_reg <= s_tdata[ID_W+CNT_W-1:ID_W];
            auto_reg   <= s_tdata[ID_W+CNT_W];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_hit_reg <= hit_reg;
            out_run_reg <= (kind_reg == KIND_TICK) ? tick_total_next : tick_total_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_run_reg, out_hit_reg};

`ifndef SYNTHESIS
    // a result only appears out of the final sequencer step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // only a check can report a timeout
    a_hit_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && hit_reg) |-> (kind_reg == KIND_CHECK))
        else $error("timeout reported for a non-check transaction");

    // run time never shows the wrap value
    a_run_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_run_reg != RUN_LIMIT))
        else $error("run time shows the wrap value");

    // tick walk stays inside the bank
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && id_ok_reg) |-> (idx_reg <= IDX_W'(TIMER_COUNT - 1)))
        else $error("timer index out of range");
`endif

endmodule

/* sv/stb_ram.sv */
// ----------------------------------------------------------------------------
// stb_ram: generic single-port RAM
// One address per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/stb_cd_unit.sv */
// ----------------------------------------------------------------------------
// stb_cd_unit: shared countdown unit
// Applies one tick to one timer: decrement, zero detect and reload.
// ----------------------------------------------------------------------------
module stb_cd_unit (
    input  logic [stb_pkg::CNT_W-1:0] count_in,
    input  logic [stb_pkg::CNT_W-1:0] reload_in,
    input  logic                      auto_in,
    output stb_pkg::cd_res_t          res
);
    import stb_pkg::*;

    logic [CNT_W-1:0] dec;

    // decrement and expiry detect
    always_comb
    begin
        dec        = count_in - CNT_W'(1);
        res.count  = count_in;
        res.expire = 1'b0;
        if (count_in != '0)
        begin
            res.count = dec;
            if (dec == '0)
            begin
                res.expire = 1'b1;
                if (auto_in)
                begin
                    res.count = reload_in;
                end
            end
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the soft timer bank
// Drives tick, start, stop and check transactions through the stream input
// and keeps a cycle-free model of the timers and run-time counter. Every
// returned transaction is compared with the model's oldest pending reply.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block fills up and back-pressures its input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    // expected content of one output transaction
    typedef struct {
        logic             timed_out;
        logic [CNT_W-1:0] run_time;
    } reply_t;

    // timer bank model plus the queue of replies it predicts
    class timer_bank_model;
        logic [CNT_W-1:0] countdown [TIMER_COUNT];
        logic [CNT_W-1:0] preload   [TIMER_COUNT];
        logic             expired   [TIMER_COUNT];
        logic             auto_mode [TIMER_COUNT];
        logic [CNT_W-1:0] tick_total;
        reply_t           expected_replies[$];
        int               mismatches;

        function new();
            foreach (countdown[t])
            begin
                countdown[t] = '0;
                preload[t]   = '0;
                expired[t]   = 1'b0;
                auto_mode[t] = 1'b0;
            end
            tick_total = '0;
            mismatches = 0;
        endfunction

        // update timer state for one accepted transaction, queue its reply
        function void apply_item(kind_t kind, logic [ID_W-1:0] id,
                                 logic [CNT_W-1:0] period, logic autor);
            reply_t r;
            bit     in_range;
            int     idx;
            r.timed_out = 1'b0;
            in_range    = (int'(id) < TIMER_COUNT);
            idx         = in_range ? int'(id) : 0;
            case (kind)
                KIND_TICK:
                begin
                    foreach (countdown[t])
                    begin
                        if (countdown[t] != '0)
                        begin
                            countdown[t] = countdown[t] - CNT_W'(1);
                            if (countdown[t] == '0)
                            begin
                                expired[t] = 1'b1;
                                if (auto_mode[t])
                                    countdown[t] = preload[t];
                            end
                        end
                    end
                    tick_total = tick_total + CNT_W'(1);
                    if (tick_total == RUN_LIMIT)
                        tick_total = '0;
                end
                KIND_START:
                begin
                    if (in_range)
                    begin
                        countdown[idx] = period;
                        preload[idx]   = period;
                        expired[idx]   = 1'b0;
                        auto_mode[idx] = autor;
                    end
                end
                KIND_STOP:
                begin
                    if (in_range)
                    begin
                        countdown[idx] = '0;
                        expired[idx]   = 1'b0;
                        auto_mode[idx] = 1'b0;
                    end
                end
                default:
                begin
                    if (in_range && expired[idx])
                    begin
                        expired[idx] = 1'b0;
                        r.timed_out  = 1'b1;
                    end
                end
            endcase
            r.run_time = tick_total;
            expected_replies.push_back(r);
        endfunction

        // compare one returned transaction with the oldest pending reply
        function void compare_reply(logic timed_out, logic [CNT_W-1:0] run_time);
            reply_t r;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected reply timed_out=%0b run_time=%0d",
                             timed_out, run_time);
                return;
            end
            r = expected_replies.pop_front();
            if (timed_out !== r.timed_out || run_time !== r.run_time)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch exp timed_out=%0b run_time=%0d got %0b %0d",
                             r.timed_out, r.run_time, timed_out, run_time);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1530;
    localparam int TICK_CYCLES  = 2 * TIMER_COUNT + 2;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // timer_id[7:0], period[39:8], auto_reload[40]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // timed_out[0], run_time[32:1]

    timer_bank_model bank;
    bit              send_quiet;
    bit              long_hold;
    int              replies_seen;

    soft_timer_bank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // offer one transaction and wait until the block takes it
    task automatic send_item(kind_t kind, logic [ID_W-1:0] id,
                             logic [CNT_W-1:0] period, logic autor);
        int gap;
        gap = pick_gap(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, autor, period, id};
        s_tuser  <= kind;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        bank.apply_item(kind, id, period, autor);
        @(negedge clk);
    endtask

    // random transaction, weighted so that timers expire often
    task automatic send_random_item();
        kind_t            kind;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] period;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = KIND_TICK;
        else if (r < 65)
            kind = KIND_START;
        else if (r < 75)
            kind = KIND_STOP;
        else
            kind = KIND_CHECK;
        if ($urandom_range(0, 99) < 85)
            id = ID_W'($urandom_range(0, TIMER_COUNT - 1));
        else
            id = ID_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 6)
            period = '0;
        else if (r < 75)
            period = $urandom_range(1, 8);
        else if (r < 90)
            period = $urandom_range(9, 40);
        else
            period = $urandom;
        send_item(kind, id, period, 1'($urandom_range(0, 1)));
    endtask

    // result side: random ready gaps, quiet stretches, one long hold-off
    initial
    begin
        int  gap;
        bit  quiet;
        logic [CNT_W-1:0] run_time;
        quiet        = 1'b0;
        replies_seen = 0;
        m_tready     = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (replies_seen % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = pick_gap(quiet);
            if (gap > 0 || long_hold)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (long_hold)
                    @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            run_time = m_tdata[32:1];
            bank.compare_reply(m_tdata[0], run_time);
            replies_seen++;
            @(negedge clk);
        end
    end

    // long receiver hold-off once traffic is flowing
    initial
    begin
        long_hold = 1'b0;
        @(posedge rst_n);
        while (replies_seen < 300)
            @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
    end

    // run limit
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // reset, directed sequence, random traffic, drain
    initial
    begin
        bank       = new();
        send_quiet = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_TICK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: flags after reset, each mode, extremes, out-of-range ids
        send_item(KIND_CHECK, 8'd0, '0, 1'b0);
        send_item(KIND_START, 8'd0, 32'd1, 1'b0);
        send_item(KIND_START, 8'd1, 32'd2, 1'b1);
        send_item(KIND_START, 8'd2, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_START, 8'd3, 32'd0, 1'b1);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_CHECK, 8'd0, '0, 1'b0);
        send_item(KIND_CHECK, 8'd0, '0, 1'b0);
        send_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_CHECK, 8'd1, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_CHECK, 8'd1, '0, 1'b0);
        send_item(KIND_STOP, 8'd1, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_CHECK, 8'd1, '0, 1'b0);
        send_item(KIND_START, 8'd4, 32'd1, 1'b1);
        send_item(KIND_START, 8'hFF, 32'd1, 1'b0);
        send_item(KIND_TICK, 8'd0, '0, 1'b0);
        send_item(KIND_CHECK, 8'hFF, '0, 1'b0);
        send_item(KIND_STOP, 8'd200, '0, 1'b0);
        send_item(KIND_CHECK, 8'd2, '0, 1'b0);
        send_item(KIND_CHECK, 8'd3, '0, 1'b0);
        send_item(KIND_STOP, 8'd2, 32'hFFFF_FFFF, 1'b1);

        // random traffic, with quiet stretches on the input side
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        s_tvalid <= 1'b0;

        // drain and let the block settle
        while (bank.pending() != 0)
            @(posedge clk);
        repeat (4 * TICK_CYCLES) @(posedge clk);

        if (bank.mismatches == 0 && bank.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
